FILE: rtl/assert_macros.svh
// Assertion helpers for the block's own checks.
// Define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/llcp_pkg.sv
package llcp_pkg;

  localparam int CPU_W     = 7;
  localparam int COUNT_W   = 8;
  localparam int TIME_W    = 48;
  localparam int LOAD_W    = 64;
  localparam int MAX_COUNT = 128;

  localparam logic KIND_ROUND  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [CPU_W-1:0]   current_cpu;
    logic [COUNT_W-1:0] cpu_count;
    logic [TIME_W-1:0]  time_used;
  } in_t;

  typedef struct packed {
    logic [CPU_W-1:0] chosen_cpu;
    logic             migrate;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY,
    ST_MOD,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  // Saturating add of a time value onto a load value.
  function automatic logic [LOAD_W-1:0] sat_add(input logic [LOAD_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [LOAD_W:0] sum;
    sum = {1'b0, a} + {{(LOAD_W - TIME_W + 1){1'b0}}, b};
    return sum[LOAD_W] ? {LOAD_W{1'b1}} : sum[LOAD_W-1:0];
  endfunction

endpackage

FILE: rtl/least_loaded_cpu_placer_top.sv
// Sample beat: busy from the accepting edge through a bit-serial remainder, a scan that reads
// count entries at one a cycle, and a write-back, with done raised in the write-back state.
// An idle cpu ends the scan early. Round-start beat: busy while load_mem is copied to exp_mem.
// A zero-time sample is accepted and gives no result. The block takes one beat at a time.
// Reset clears every entry of both tables with busy high; done is never stalled.
`include "assert_macros.svh"

module least_loaded_cpu_placer_top #(
  parameter int NUM_PCPUS = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  llcp_pkg::in_t    item,
  output logic             done,
  output llcp_pkg::out_t   result
);
  import llcp_pkg::*;

  // Address width of the tables, and a counter width that can also hold NUM_PCPUS itself.
  localparam int AW          = (NUM_PCPUS > 1) ? $clog2(NUM_PCPUS) : 1;
  localparam int CW          = AW + 1;
  localparam int COUNT_LIMIT = (NUM_PCPUS < MAX_COUNT) ? NUM_PCPUS : MAX_COUNT;

  // The two tables. Each has one write port and one registered read port.
  logic [LOAD_W-1:0] load_mem [NUM_PCPUS];
  logic [LOAD_W-1:0] exp_mem  [NUM_PCPUS];
  logic [LOAD_W-1:0] load_rd;
  logic [LOAD_W-1:0] exp_rd;

  state_t state, state_next;

  // Sweep counter shared by the clearing pass after reset and by the round-start copy.
  logic [CW-1:0] cnt;

  // Fields of the sample being worked on.
  logic [CPU_W-1:0]  cur;
  logic [TIME_W-1:0] tused;
  logic [CW-1:0]     count_lim;

  // Restoring remainder of current_cpu by the clamped count, one bit per cycle.
  logic [COUNT_W-1:0] rem;
  logic [2:0]         bitpos;
  logic [COUNT_W-1:0] rem_shift;
  logic [COUNT_W-1:0] rem_next;
  logic [COUNT_W-1:0] count8;

  // Scan state. Reads are issued one per cycle; the data comes back in the next cycle.
  logic [AW-1:0]     idx;
  logic [CW-1:0]     issued;
  logic [CW-1:0]     seen;
  logic              rd_vld;
  logic [AW-1:0]     rd_idx;
  logic              best_vld;
  logic [AW-1:0]     best;
  logic [LOAD_W-1:0] best_val;

  logic              issue;
  logic              take;
  logic              scan_last;
  logic              scan_finish;
  logic [AW-1:0]     best_next;
  logic [LOAD_W-1:0] best_val_next;
  logic [CW-1:0]     idx_inc;

  logic              accept;
  logic [CW-1:0]     count_in;
  logic              cur_in_range;

  // Memory port controls.
  logic              exp_we;
  logic [AW-1:0]     exp_waddr;
  logic [LOAD_W-1:0] exp_wdata;
  logic              load_we;
  logic [AW-1:0]     load_waddr;
  logic [LOAD_W-1:0] load_wdata;
  logic [AW-1:0]     load_raddr;

  assign accept = start && !busy;

  // The count is clamped to the range from one to the smaller of NUM_PCPUS and 128.
  always_comb begin
    if (item.cpu_count == '0) begin
      count_in = CW'(1);
    end else if (int'(item.cpu_count) > COUNT_LIMIT) begin
      count_in = CW'(COUNT_LIMIT);
    end else begin
      count_in = CW'(item.cpu_count);
    end
  end

  assign count8       = COUNT_W'(count_lim);
  assign rem_shift    = {rem[COUNT_W-2:0], cur[bitpos]};
  assign rem_next     = (rem_shift >= count8) ? (rem_shift - count8) : rem_shift;
  assign cur_in_range = int'(cur) < NUM_PCPUS;

  // A scanned entry becomes the new best if it is the first or strictly smaller. A zero
  // entry ends the scan at once; since any earlier best is nonzero, it is also taken here.
  assign take          = rd_vld && (!best_vld || (exp_rd < best_val));
  assign best_next     = take ? rd_idx : best;
  assign best_val_next = take ? exp_rd : best_val;
  assign scan_last     = rd_vld && (seen == count_lim - CW'(1));
  assign scan_finish   = rd_vld && ((exp_rd == '0) || scan_last);
  assign issue         = (state == ST_SCAN) && (issued < count_lim) && !scan_finish;
  assign idx_inc       = {1'b0, idx} + CW'(1);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (cnt == CW'(NUM_PCPUS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (item.kind == KIND_ROUND) begin
            state_next = ST_COPY;
          end else if (item.time_used != '0) begin
            state_next = ST_MOD;
          end
        end
      end
      ST_COPY: begin
        if (cnt == CW'(NUM_PCPUS)) state_next = ST_IDLE;
      end
      ST_MOD: begin
        if (bitpos == 3'd0) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_finish) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and memory port controls.
  always_comb begin
    busy       = 1'b1;
    done       = 1'b0;
    exp_we     = 1'b0;
    exp_waddr  = cnt[AW-1:0];
    exp_wdata  = '0;
    load_we    = 1'b0;
    load_waddr = cnt[AW-1:0];
    load_wdata = '0;
    load_raddr = AW'(cur);
    unique case (state)
      ST_CLEAR: begin
        exp_we  = 1'b1;
        load_we = 1'b1;
      end
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_COPY: begin
        // Read entry cnt now, write entry cnt - 1 with the data read last cycle.
        load_raddr = cnt[AW-1:0];
        exp_we     = (cnt != '0);
        exp_waddr  = AW'(cnt - CW'(1));
        exp_wdata  = load_rd;
      end
      ST_MOD, ST_SCAN: begin
      end
      ST_UPDATE: begin
        done       = 1'b1;
        exp_we     = 1'b1;
        exp_waddr  = best;
        exp_wdata  = sat_add(best_val, tused);
        load_we    = cur_in_range;
        load_waddr = AW'(cur);
        load_wdata = sat_add(load_rd, tused);
      end
      default: begin
      end
    endcase
  end

  assign result.chosen_cpu = CPU_W'(best);
  assign result.migrate    = (CPU_W'(best) != cur);

  // Memories. During a sample the load read port keeps reading load_mem[cur], so load_rd
  // holds that entry by the time of the write-back; nothing writes load_mem meanwhile.
  always_ff @(posedge clk) begin
    if (exp_we) exp_mem[exp_waddr] <= exp_wdata;
    exp_rd <= exp_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (load_we) load_mem[load_waddr] <= load_wdata;
    load_rd <= load_mem[load_raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cnt      <= '0;
      rd_vld   <= 1'b0;
      best_vld <= 1'b0;
    end else begin
      state <= state_next;

      if (state == ST_CLEAR || state == ST_COPY) begin
        cnt <= cnt + CW'(1);
      end else begin
        cnt <= '0;
      end

      rd_vld <= issue;

      if (state == ST_SCAN) begin
        best_vld <= best_vld || rd_vld;
      end else begin
        best_vld <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur       <= item.current_cpu;
      tused     <= item.time_used;
      count_lim <= count_in;
      rem       <= '0;
      bitpos    <= 3'(CPU_W - 1);
    end else if (state == ST_MOD) begin
      rem    <= rem_next;
      bitpos <= bitpos - 3'd1;
    end

    if (state == ST_MOD) begin
      // The scan starts at current_cpu mod count.
      idx    <= AW'(rem_next);
      issued <= '0;
      seen   <= '0;
    end else if (issue) begin
      idx    <= (idx_inc >= count_lim) ? '0 : idx_inc[AW-1:0];
      issued <= issued + CW'(1);
    end

    rd_idx <= idx;

    if (state == ST_SCAN && rd_vld) begin
      seen     <= seen + CW'(1);
      best     <= best_next;
      best_val <= best_val_next;
    end
  end

  // A result only follows the end of a scan.
  `ASSERT_SAME(a_done_after_scan, clk, rst, done, $past(state) == ST_SCAN)
  // The scan never looks at more entries than the clamped count.
  `ASSERT_SAME(a_seen_in_count, clk, rst, rd_vld, seen < count_lim)
  // The scan pointer stays inside the usable range.
  `ASSERT_SAME(a_idx_in_count, clk, rst, state == ST_SCAN, CW'(idx) < count_lim)
  // A round-start beat always enters the copy sweep.
  `ASSERT_NEXT(a_round_copies, clk, rst, accept && (item.kind == KIND_ROUND),
               (state == ST_COPY) && busy)

endmodule
